// ===== sv/i2cw_pkg.sv =====
// Shared types and constants for the I2C master write engine.
`timescale 1ns / 1ps
`default_nettype none

package i2cw_pkg;

    localparam logic [15:0] PHASE_TICKS_RESET = 16'd100;
    localparam logic [3:0]  BITS_PER_BYTE     = 4'd8;
    localparam int          BIT7              = 7;
    localparam int          BIT6              = 6;

    // command queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [9:0] {
        PH_IDLE      = 10'b00_0000_0001,
        PH_START_A   = 10'b00_0000_0010,
        PH_START_B   = 10'b00_0000_0100,
        PH_BIT_HIGH  = 10'b00_0000_1000,
        PH_BIT_LOW   = 10'b00_0001_0000,
        PH_ACK_HIGH  = 10'b00_0010_0000,
        PH_ACK_LOW   = 10'b00_0100_0000,
        PH_WAIT      = 10'b00_1000_0000,
        PH_STOP_LOW  = 10'b01_0000_0000,
        PH_STOP_HIGH = 10'b10_0000_0000
    } phase_t;

    typedef struct packed {
        logic scl_lvl;
        logic scl_en;
        logic sda_lvl;
        logic sda_en;
    } drive_t;

    typedef struct packed {
        logic       byte_valid;
        logic [7:0] byte_data;
        logic       byte_final;
        logic       sda_sample;
    } in_item_t;

    typedef struct packed {
        logic scl_level;
        logic scl_enable;
        logic sda_level;
        logic sda_enable;
        logic byte_taken;
        logic busy_res;
        logic done_ok;
        logic nack_error;
    } out_item_t;

    function automatic drive_t mk_drive(input logic scl_lvl, input logic scl_en,
                                        input logic sda_lvl, input logic sda_en);
        drive_t d;
        d.scl_lvl = scl_lvl;
        d.scl_en  = scl_en;
        d.sda_lvl = sda_lvl;
        d.sda_en  = sda_en;
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== sv/i2cw_if.sv =====
// Valid/ready channel interfaces for tick words in and line words out.
`timescale 1ns / 1ps
`default_nettype none

interface i2cw_in_if;
    logic               valid;
    logic               ready;
    i2cw_pkg::in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface i2cw_out_if;
    logic                valid;
    logic                ready;
    i2cw_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/i2c_master_write_engine.sv =====
// Top level of the write-only I2C master engine.
//
// Usage:
//   ingress carries one word per bus tick: byte_valid/byte_data/byte_final
//   offer the next byte, sda_sample is the sampled SDA level.
//   egress returns one word per ingress word: SCL/SDA drive values and
//   enables plus byte_taken, busy_res and the done_ok/nack_error pulses.
//   cfg_we/cfg_wdata load phase_ticks (ticks per bus phase, 0 acts as 1);
//   write it only while no words are in flight.
// Path: an accepted word is written into the two-entry queue, is stepped
//   by the sequencer into the output register and waits there until
//   egress takes it.
// Throughput: one word per cycle if egress is ready; single-step sequencer.
// Reset: queue empty, no output word, engine idle with both lines driven
//   high, phase_ticks = 100.
// Stall: while egress is not ready the output word holds, the sequencer
//   stops and the queue fills; ingress.ready drops once two words wait.
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_write_engine (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,
    i2cw_in_if.sink          ingress,
    i2cw_out_if.source       egress
);
    import i2cw_pkg::*;

    in_item_t q_item;
    logic     q_valid;
    logic     q_pop;

    i2cw_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .ingress (ingress),
        .q_item  (q_item),
        .q_valid (q_valid),
        .q_pop   (q_pop)
    );

    i2cw_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_item    (q_item),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .egress    (egress)
    );

endmodule

`default_nettype wire

// ===== sv/i2cw_front.sv =====
// Front end: accepts tick words and holds them in a short queue for the engine.
`timescale 1ns / 1ps
`default_nettype none

module i2cw_front (
    input  wire logic         clk,
    input  wire logic         rst_n,
    i2cw_in_if.sink           ingress,
    output i2cw_pkg::in_item_t q_item,
    output logic              q_valid,
    input  wire logic         q_pop
);
    import i2cw_pkg::*;

    in_item_t           mem_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               push;
    logic               pop;

    assign ingress.ready = (count_reg != QCNT_W'(QDEPTH));
    assign push          = ingress.valid && ingress.ready;
    assign q_valid       = (count_reg != '0);
    assign pop           = q_pop && q_valid;
    assign q_item        = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= ingress.data;
        end
    end

endmodule

`default_nettype wire

// ===== sv/i2cw_back.sv =====
// Back end: bus phase sequencer, one tick word per step, with a registered output word.
`timescale 1ns / 1ps
`default_nettype none

module i2cw_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [15:0]        cfg_wdata,
    input  wire i2cw_pkg::in_item_t q_item,
    input  wire logic               q_valid,
    output logic                    q_pop,
    i2cw_out_if.source              egress
);
    import i2cw_pkg::*;

    logic [15:0] phase_ticks_reg;
    phase_t      phase_reg, phase_next;
    logic [3:0]  bit_count_reg, bit_count_next;
    logic [7:0]  shift_reg, shift_next;
    logic        final_reg, final_next;
    logic [15:0] tick_reg, tick_next;
    drive_t      drive_reg, drive_next;
    logic        out_valid_reg;
    out_item_t   out_data_reg;
    out_item_t   word_next;
    logic        step;
    logic        timed;
    logic        expired;
    logic        taken, done, nack;
    logic [3:0]  bit_count_inc;

    assign step          = q_valid && (!out_valid_reg || egress.ready);
    assign q_pop         = step;
    assign expired       = (tick_reg >= phase_ticks_reg);
    assign bit_count_inc = bit_count_reg + 4'd1;

    always_comb
    begin
        phase_next     = phase_reg;
        bit_count_next = bit_count_reg;
        shift_next     = shift_reg;
        final_next     = final_reg;
        tick_next      = tick_reg;
        drive_next     = drive_reg;
        taken          = 1'b0;
        done           = 1'b0;
        nack           = 1'b0;
        timed          = 1'b1;

        unique case (phase_reg) inside
            PH_IDLE, PH_WAIT:
            begin
                timed = 1'b0;
                if (q_item.byte_valid)
                begin
                    taken          = 1'b1;
                    shift_next     = q_item.byte_data;
                    final_next     = q_item.byte_final;
                    bit_count_next = '0;
                    tick_next      = 16'd1;
                    if (phase_reg == PH_IDLE)
                    begin
                        phase_next = PH_START_A;
                        drive_next = mk_drive(1'b1, 1'b1, 1'b0, 1'b1);
                    end
                    else
                    begin
                        phase_next = PH_BIT_HIGH;
                        drive_next = mk_drive(1'b1, 1'b1, q_item.byte_data[BIT7], 1'b1);
                    end
                end
            end
            PH_START_A:
            begin
                phase_next = PH_START_B;
                drive_next = mk_drive(1'b0, 1'b1, 1'b0, 1'b1);
                tick_next  = 16'd1;
            end
            PH_START_B:
            begin
                phase_next = PH_BIT_HIGH;
                drive_next = mk_drive(1'b1, 1'b1, shift_reg[BIT7], 1'b1);
                tick_next  = 16'd1;
            end
            PH_BIT_HIGH:
            begin
                phase_next = PH_BIT_LOW;
                drive_next = mk_drive(1'b0, 1'b1, shift_reg[BIT7], 1'b1);
                tick_next  = 16'd1;
            end
            PH_BIT_LOW:
            begin
                shift_next     = {shift_reg[6:0], 1'b0};
                bit_count_next = bit_count_inc;
                tick_next      = 16'd1;
                if (bit_count_inc >= BITS_PER_BYTE)
                begin
                    phase_next = PH_ACK_HIGH;
                    drive_next = mk_drive(1'b1, 1'b1, 1'b1, 1'b0);
                end
                else
                begin
                    // next bit is the one below the current MSB
                    phase_next = PH_BIT_HIGH;
                    drive_next = mk_drive(1'b1, 1'b1, shift_reg[BIT6], 1'b1);
                end
            end
            PH_ACK_HIGH:
            begin
                if (q_item.sda_sample)
                begin
                    nack       = 1'b1;
                    phase_next = PH_IDLE;
                    tick_next  = '0;
                    drive_next = mk_drive(1'b1, 1'b0, 1'b1, 1'b0);
                end
                else
                begin
                    phase_next = PH_ACK_LOW;
                    drive_next = mk_drive(1'b0, 1'b1, 1'b1, 1'b0);
                    tick_next  = 16'd1;
                end
            end
            PH_ACK_LOW:
            begin
                drive_next = mk_drive(1'b0, 1'b1, 1'b0, 1'b1);
                if (final_reg)
                begin
                    phase_next = PH_STOP_LOW;
                    tick_next  = 16'd1;
                end
                else
                begin
                    phase_next = PH_WAIT;
                    tick_next  = '0;
                end
            end
            PH_STOP_LOW:
            begin
                phase_next = PH_STOP_HIGH;
                drive_next = mk_drive(1'b1, 1'b1, 1'b0, 1'b1);
                tick_next  = 16'd1;
            end
            PH_STOP_HIGH:
            begin
                done       = 1'b1;
                phase_next = PH_IDLE;
                tick_next  = '0;
                drive_next = mk_drive(1'b1, 1'b1, 1'b1, 1'b1);
            end
            default:
            begin
                timed      = 1'b0;
                phase_next = PH_IDLE;
                tick_next  = '0;
                drive_next = mk_drive(1'b1, 1'b1, 1'b1, 1'b1);
            end
        endcase

        // phase still running: only the tick counter moves
        if (timed && !expired)
        begin
            phase_next     = phase_reg;
            bit_count_next = bit_count_reg;
            shift_next     = shift_reg;
            final_next     = final_reg;
            drive_next     = drive_reg;
            tick_next      = tick_reg + 16'd1;
            done           = 1'b0;
            nack           = 1'b0;
        end

        word_next.scl_level  = drive_next.scl_lvl;
        word_next.scl_enable = drive_next.scl_en;
        word_next.sda_level  = drive_next.sda_lvl;
        word_next.sda_enable = drive_next.sda_en;
        word_next.byte_taken = taken;
        word_next.busy_res   = (phase_next != PH_IDLE);
        word_next.done_ok    = done;
        word_next.nack_error = nack;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_ticks_reg <= PHASE_TICKS_RESET;
            phase_reg       <= PH_IDLE;
            bit_count_reg   <= '0;
            shift_reg       <= '0;
            final_reg       <= 1'b0;
            tick_reg        <= '0;
            drive_reg       <= mk_drive(1'b1, 1'b1, 1'b1, 1'b1);
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                phase_ticks_reg <= cfg_wdata;
            end
            if (step)
            begin
                phase_reg     <= phase_next;
                bit_count_reg <= bit_count_next;
                shift_reg     <= shift_next;
                final_reg     <= final_next;
                tick_reg      <= tick_next;
                drive_reg     <= drive_next;
                out_valid_reg <= 1'b1;
            end
            else if (egress.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_data_reg <= word_next;
        end
    end

    assign egress.valid = out_valid_reg;
    assign egress.data  = out_data_reg;

endmodule

`default_nettype wire

// ===== sv/i2cw_checker.sv =====
// Port-level checks on the engine's output words, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module i2cw_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                out_valid,
    input wire logic                out_ready,
    input wire i2cw_pkg::out_item_t out_word
);

    // a finished stop leaves the bus idle with both lines driven high
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.done_ok |->
            !out_word.busy_res && !out_word.nack_error &&
            out_word.scl_level && out_word.scl_enable &&
            out_word.sda_level && out_word.sda_enable)
        else $error("done word without idle bus");

    // an abort releases both lines
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.nack_error |->
            !out_word.busy_res && !out_word.scl_enable && !out_word.sda_enable)
        else $error("nack word with lines still driven");

    // a taken byte always starts or continues a transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.byte_taken |->
            out_word.busy_res && out_word.scl_enable && out_word.sda_enable)
        else $error("byte taken while not busy");

    // stalled output word is held
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_word))
        else $error("output word dropped under stall");

endmodule

bind i2c_master_write_engine i2cw_checker u_i2cw_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (egress.valid),
    .out_ready (egress.ready),
    .out_word  (egress.data)
);

`default_nettype wire

// ===== dv/i2c_master_write_engine_test.sv =====
// Self-checking testbench for the I2C master write engine: tick words in, line words out.
`timescale 1ns / 1ps

module i2c_master_write_engine_test;
    import i2cw_pkg::*;

    localparam int STALL_LIMIT = 4000;

    typedef struct {
        phase_t      phase;
        logic [3:0]  bits_sent;
        logic [7:0]  shifter;
        logic        last_byte;
        logic [15:0] elapsed;
        drive_t      lines;
    } engine_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    i2cw_in_if  tick_ch ();
    i2cw_out_if line_ch ();

    i2c_master_write_engine dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .ingress   (tick_ch),
        .egress    (line_ch)
    );

    // generator side shapes stimulus, bus side predicts at acceptance
    engine_t     gen_state;
    engine_t     bus_state;
    logic [15:0] gen_ticks;
    logic [15:0] bus_ticks;

    in_item_t  tick_queue[$];
    out_item_t expected_lines[$];

    int    words_queued;
    int    results_seen;
    int    mismatches;
    int    send_gap;
    int    send_calm;
    int    recv_gap;
    int    recv_calm;
    int    hold_left;
    bit    held_long;
    bit    in_fired;
    int    quiet_cycles;
    string field_tag [8] = '{"nack_error", "done_ok", "busy_res", "byte_taken",
                             "sda_enable", "sda_level", "scl_enable", "scl_level"};

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic engine_t engine_idle();
        engine_t s;
        s.phase     = PH_IDLE;
        s.bits_sent = 4'd0;
        s.shifter   = 8'd0;
        s.last_byte = 1'b0;
        s.elapsed   = 16'd0;
        s.lines     = 4'b1111;
        return s;
    endfunction

    // One bus tick. Drive order in lines: scl_lvl, scl_en, sda_lvl, sda_en.
    function automatic out_item_t engine_step(inout engine_t s, input logic [15:0] ticks,
                                              input in_item_t w);
        out_item_t r;
        r = '0;
        if (s.phase == PH_IDLE || s.phase == PH_WAIT)
        begin
            if (w.byte_valid)
            begin
                r.byte_taken = 1'b1;
                s.shifter    = w.byte_data;
                s.last_byte  = w.byte_final;
                s.bits_sent  = 4'd0;
                s.elapsed    = 16'd1;
                if (s.phase == PH_IDLE)
                begin
                    s.phase = PH_START_A;
                    s.lines = 4'b1101;
                end
                else
                begin
                    s.phase = PH_BIT_HIGH;
                    s.lines = {2'b11, s.shifter[BIT7], 1'b1};
                end
            end
        end
        else if (s.elapsed < ticks)
        begin
            s.elapsed = s.elapsed + 16'd1;
        end
        else
        begin
            s.elapsed = 16'd1;
            case (s.phase)
                PH_START_A:
                begin
                    s.phase = PH_START_B;
                    s.lines = 4'b0101;
                end
                PH_START_B:
                begin
                    s.phase = PH_BIT_HIGH;
                    s.lines = {2'b11, s.shifter[BIT7], 1'b1};
                end
                PH_BIT_HIGH:
                begin
                    s.phase = PH_BIT_LOW;
                    s.lines = {2'b01, s.shifter[BIT7], 1'b1};
                end
                PH_BIT_LOW:
                begin
                    s.shifter   = {s.shifter[6:0], 1'b0};
                    s.bits_sent = s.bits_sent + 4'd1;
                    if (s.bits_sent >= BITS_PER_BYTE)
                    begin
                        s.phase = PH_ACK_HIGH;
                        s.lines = 4'b1110;
                    end
                    else
                    begin
                        s.phase = PH_BIT_HIGH;
                        s.lines = {2'b11, s.shifter[BIT7], 1'b1};
                    end
                end
                PH_ACK_HIGH:
                begin
                    if (w.sda_sample)
                    begin
                        // no acknowledge: release both lines and abort
                        r.nack_error = 1'b1;
                        s.phase      = PH_IDLE;
                        s.elapsed    = 16'd0;
                        s.lines      = 4'b1010;
                    end
                    else
                    begin
                        s.phase = PH_ACK_LOW;
                        s.lines = 4'b0110;
                    end
                end
                PH_ACK_LOW:
                begin
                    s.lines = 4'b0101;
                    if (s.last_byte)
                    begin
                        s.phase = PH_STOP_LOW;
                    end
                    else
                    begin
                        s.phase   = PH_WAIT;
                        s.elapsed = 16'd0;
                    end
                end
                PH_STOP_LOW:
                begin
                    s.phase = PH_STOP_HIGH;
                    s.lines = 4'b1101;
                end
                PH_STOP_HIGH:
                begin
                    r.done_ok = 1'b1;
                    s.phase   = PH_IDLE;
                    s.elapsed = 16'd0;
                    s.lines   = 4'b1111;
                end
                default:
                begin
                    s.phase   = PH_IDLE;
                    s.elapsed = 16'd0;
                    s.lines   = 4'b1111;
                end
            endcase
        end
        r.scl_level  = s.lines.scl_lvl;
        r.scl_enable = s.lines.scl_en;
        r.sda_level  = s.lines.sda_lvl;
        r.sda_enable = s.lines.sda_en;
        r.busy_res   = (s.phase != PH_IDLE);
        return r;
    endfunction

    // mostly short gaps, a few long ones, now and then a calm stretch
    function automatic int gap_len(inout int calm);
        int r;
        if (calm != 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 9);
        return $urandom_range(10, 30);
    endfunction

    task automatic push_tick(input logic valid, input logic [7:0] data, input logic last,
                             input logic sda);
        in_item_t w;
        w.byte_valid = valid;
        w.byte_data  = data;
        w.byte_final = last;
        w.sda_sample = sda;
        void'(engine_step(gen_state, gen_ticks, w));
        tick_queue.push_back(w);
        words_queued++;
    endtask

    task automatic filler(input int n);
        repeat (n)
            push_tick($urandom_range(0, 3) == 0, 8'($urandom), 1'($urandom), 1'($urandom));
    endtask

    // run the engine to the next byte boundary; offers made meanwhile are ignored
    task automatic finish_byte(input logic bad_ack);
        logic sda;
        while (gen_state.phase != PH_IDLE && gen_state.phase != PH_WAIT)
        begin
            if (gen_state.phase == PH_ACK_HIGH && !(gen_state.elapsed < gen_ticks))
                sda = bad_ack;
            else
                sda = 1'($urandom);
            push_tick($urandom_range(0, 3) == 0, 8'($urandom), 1'($urandom), sda);
        end
    endtask

    task automatic send_byte(input logic [7:0] data, input logic last, input logic bad_ack);
        push_tick(1'b1, data, last, 1'($urandom));
        finish_byte(bad_ack);
    endtask

    task automatic random_traffic(input int n);
        int stop_at;
        stop_at = words_queued + n;
        while (words_queued < stop_at)
        begin
            if ($urandom_range(0, 9) < 2)
                push_tick(1'b0, 8'($urandom), 1'($urandom), 1'($urandom));
            else
                send_byte(8'($urandom), $urandom_range(0, 2) == 0, $urandom_range(0, 11) == 0);
        end
    endtask

    task automatic wait_drained();
        while (tick_queue.size() != 0 || expected_lines.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_ticks(input logic [15:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        bus_ticks = value;
        gen_ticks = value;
    endtask

    // input side: hold a word until taken, then maybe idle
    always @(negedge clk)
    begin
        if (!rst_n)
            tick_ch.valid <= 1'b0;
        else if (!tick_ch.valid || in_fired)
        begin
            if (send_gap != 0)
            begin
                send_gap--;
                tick_ch.valid <= 1'b0;
            end
            else if (tick_queue.size() != 0)
            begin
                tick_ch.valid <= 1'b1;
                tick_ch.data  <= tick_queue[0];
            end
            else
                tick_ch.valid <= 1'b0;
        end
    end

    // output side stalls; one long hold while words keep coming
    always @(negedge clk)
    begin
        if (!rst_n)
            line_ch.ready <= 1'b1;
        else if (hold_left != 0)
        begin
            hold_left--;
            line_ch.ready <= 1'b0;
        end
        else if (!held_long && results_seen >= 350 && tick_queue.size() > 20)
        begin
            held_long = 1'b1;
            hold_left = 63;
            line_ch.ready <= 1'b0;
        end
        else if (recv_gap != 0)
        begin
            recv_gap--;
            line_ch.ready <= 1'b0;
        end
        else
        begin
            line_ch.ready <= 1'b1;
            recv_gap = gap_len(recv_calm);
        end
    end

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n)
        begin
            in_fired = 1'b0;
            if (tick_ch.valid && tick_ch.ready)
            begin
                expected_lines.push_back(engine_step(bus_state, bus_ticks, tick_ch.data));
                void'(tick_queue.pop_front());
                in_fired = 1'b1;
                send_gap = gap_len(send_calm);
            end
            if (line_ch.valid && line_ch.ready)
            begin
                results_seen++;
                if (expected_lines.size() == 0)
                begin
                    $error("line word with nothing expected: %b", line_ch.data);
                    mismatches++;
                end
                else
                begin
                    want = expected_lines.pop_front();
                    for (int b = 7; b >= 0; b--)
                    begin
                        if (line_ch.data[b] !== want[b])
                        begin
                            $error("%s: expected %0b, got %0b", field_tag[b], want[b],
                                   line_ch.data[b]);
                            mismatches++;
                        end
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((tick_ch.valid && tick_ch.ready) || (line_ch.valid && line_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = 16'd0;
        tick_ch.valid = 1'b0;
        tick_ch.data  = '0;
        line_ch.ready = 1'b1;
        gen_state     = engine_idle();
        bus_state     = engine_idle();
        gen_ticks     = PHASE_TICKS_RESET;
        bus_ticks     = PHASE_TICKS_RESET;
        words_queued  = 0;
        results_seen  = 0;
        mismatches    = 0;
        send_gap      = 0;
        send_calm     = 0;
        recv_gap      = 0;
        recv_calm     = 0;
        hold_left     = 0;
        held_long     = 1'b0;
        in_fired      = 1'b0;
        quiet_cycles  = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset phase length: start a transfer and count inside the start phase
        push_tick(1'b0, 8'h00, 1'b0, 1'b1);
        push_tick(1'b1, 8'hC3, 1'b0, 1'b0);
        filler(18);
        wait_drained();

        // longest phase, changed mid-phase
        write_ticks(16'hFFFF);
        filler(8);
        wait_drained();

        // zero acts as one tick per phase
        write_ticks(16'd0);
        finish_byte(1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        repeat (3) push_tick(1'b0, 8'($urandom), 1'($urandom), 1'($urandom));
        send_byte(8'h00, 1'b1, 1'b0);
        send_byte(8'hA5, 1'b0, 1'b1);
        push_tick(1'b0, 8'h00, 1'b0, 1'b1);
        send_byte(8'h5A, 1'b1, 1'b0);
        send_byte(8'h01, 1'b0, 1'b0);
        send_byte(8'h80, 1'b1, 1'b1);
        wait_drained();

        write_ticks(16'd1);
        random_traffic(80);
        wait_drained();

        write_ticks(16'd2);
        random_traffic(80);
        wait_drained();

        write_ticks(16'($urandom_range(3, 6)));
        random_traffic(80);
        wait_drained();

        write_ticks(16'd0);
        random_traffic(40);
        wait_drained();
        repeat (4) @(posedge clk);

        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
